/* rtl/core/ddd_pkg.sv */
// Shared types, constants and calendar tables for the date difference block.
package ddd_pkg;

    // Field widths
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 12;
    localparam int DNUM_W   = 20;
    localparam int STATUS_W = 2;

    // Valid year range and calendar constants
    localparam logic [YEAR_W-1:0]  YEAR_MIN      = 12'd1583;
    localparam logic [YEAR_W-1:0]  YEAR_MAX      = 12'd2399;
    localparam logic [MONTH_W-1:0] MONTH_FIRST   = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB     = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_LAST    = 4'd12;
    localparam logic [DAY_W-1:0]   FEB_LEAP_DAYS = 5'd29;

    // x / 100 == (x * 5243) >> 19 for every 12-bit x
    localparam int             DIV100_SHIFT = 19;
    localparam logic [12:0]    DIV100_MUL   = 13'd5243;
    localparam int             PROD_W       = YEAR_W + 13;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FIRST_BAD  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SECOND_BAD = 2'd2;

    typedef struct packed {
        logic [DAY_W-1:0]   first_day;
        logic [MONTH_W-1:0] first_month;
        logic [YEAR_W-1:0]  first_year;
        logic [DAY_W-1:0]   second_day;
        logic [MONTH_W-1:0] second_month;
        logic [YEAR_W-1:0]  second_year;
    } in_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DNUM_W-1:0] day_difference;
        logic                     first_earlier;
        logic                     same_date;
    } out_word_t;

    // Days in a month of a common year; 0 for month codes that mean nothing
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Days in a common year before the first of the month
    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
        logic [8:0] n;
        case (m)
            4'd1:    n = 9'd0;
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

/* rtl/core/date_day_difference.sv */
// Top level: date validation and signed day difference between two dates.
//
//   channel | ports                      | direction | word
//   --------+----------------------------+-----------+-----------
//   input   | s_valid, s_ready, s_word   | in        | in_word_t
//   result  | m_valid, m_ready, m_word   | out       | out_word_t
//
// One word per cycle while m_ready does not stall the result stage; a word
// passes through the input register, then the result register, from which
// m_word is driven.
// Both dates are converted in parallel between the two registers.
// Reset (aresetn low, synchronous) empties both stages.
// A stall on m_ready backs up one stage at a time; s_ready stays high while
// the input stage is empty or moving forward.
module date_day_difference
    import ddd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_word,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_word
);

    logic      in_valid_reg, in_valid_next;
    in_word_t  in_word_reg;
    logic      out_valid_reg, out_valid_next;
    out_word_t out_word_reg, out_word_next;
    logic      out_ready;

    logic              first_ok, second_ok;
    logic [DNUM_W-1:0] first_num, second_num;

    // Handshake between stages
    assign out_ready = !out_valid_reg || m_ready;
    assign s_ready   = !in_valid_reg || out_ready;
    assign m_valid   = out_valid_reg;
    assign m_word    = out_word_reg;

    ddd_date_unit u_first (
        .day     (in_word_reg.first_day),
        .month   (in_word_reg.first_month),
        .year    (in_word_reg.first_year),
        .date_ok (first_ok),
        .day_num (first_num)
    );

    ddd_date_unit u_second (
        .day     (in_word_reg.second_day),
        .month   (in_word_reg.second_month),
        .year    (in_word_reg.second_year),
        .date_ok (second_ok),
        .day_num (second_num)
    );

    // Result word
    always_comb begin
        out_word_next = '0;
        if (!first_ok) begin
            out_word_next.status = STATUS_FIRST_BAD;
        end else if (!second_ok) begin
            out_word_next.status = STATUS_SECOND_BAD;
        end else begin
            out_word_next.status         = STATUS_OK;
            out_word_next.day_difference = second_num - first_num;
            out_word_next.first_earlier  = first_num < second_num;
            out_word_next.same_date      = first_num == second_num;
        end
    end

    // Stage valid flags
    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
        if (out_ready) begin
            out_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_word_reg <= s_word;
        end
        if (out_ready && in_valid_reg) begin
            out_word_reg <= out_word_next;
        end
    end

endmodule

/* rtl/core/ddd_date_unit.sv */
// Checks one calendar date and converts it to a running day number.
module ddd_date_unit
    import ddd_pkg::*;
(
    input  logic [DAY_W-1:0]   day,
    input  logic [MONTH_W-1:0] month,
    input  logic [YEAR_W-1:0]  year,
    output logic               date_ok,
    output logic [DNUM_W-1:0]  day_num
);

    logic [PROD_W-1:0] y_prod;
    logic [5:0]        y_div100;
    logic [PROD_W-1:0] y_rem_full;
    logic [6:0]        y_rem100;
    logic              leap;
    logic [DAY_W-1:0]  last_day;
    logic [YEAR_W-1:0] p;
    logic [PROD_W-1:0] p_prod;
    logic [5:0]        p_div100;
    logic [DNUM_W:0]   n_sum;

    // Leap year: divisible by 4 and not by 100, or divisible by 400
    assign y_prod     = PROD_W'(year) * PROD_W'(DIV100_MUL);
    assign y_div100   = y_prod[DIV100_SHIFT +: 6];
    assign y_rem_full = PROD_W'(year) - PROD_W'(y_div100) * PROD_W'(100);
    assign y_rem100   = y_rem_full[6:0];
    assign leap       = ((year[1:0] == 2'd0) && (y_rem100 != 7'd0))
                     || ((y_rem100 == 7'd0) && (y_div100[1:0] == 2'd0));

    // Range check of the date
    always_comb begin
        last_day = month_len(month);
        if (month == MONTH_FEB && leap) begin
            last_day = FEB_LEAP_DAYS;
        end
        date_ok = (month inside {[MONTH_FIRST:MONTH_LAST]})
               && (year inside {[YEAR_MIN:YEAR_MAX]})
               && (day != '0) && (day <= last_day);
    end

    // Day number: whole years before this one, then months and days
    assign p        = year - YEAR_W'(1);
    assign p_prod   = PROD_W'(p) * PROD_W'(DIV100_MUL);
    assign p_div100 = p_prod[DIV100_SHIFT +: 6];
    assign n_sum    = (DNUM_W+1)'(p) * (DNUM_W+1)'(365)
                    + (DNUM_W+1)'(p[YEAR_W-1:2])
                    - (DNUM_W+1)'(p_div100)
                    + (DNUM_W+1)'(p_div100[5:2])
                    + (DNUM_W+1)'(days_before(month))
                    + (DNUM_W+1)'(day)
                    + (DNUM_W+1)'((month > MONTH_FEB) && leap);
    assign day_num  = n_sum[DNUM_W-1:0];

endmodule

/* dv/date_day_difference_tb.sv */
// Testbench for date_day_difference: directed table plus random words, self-checking.
module date_day_difference_tb
    import ddd_pkg::*;
();

    localparam int NUM_RANDOM = 1628;
    localparam int DRAIN_CYCLES = 8;

    // Typed results for invalid dates and for fixed valid differences
    localparam out_word_t FIRST_BAD_WORD  = '{STATUS_FIRST_BAD, '0, 1'b0, 1'b0};
    localparam out_word_t SECOND_BAD_WORD = '{STATUS_SECOND_BAD, '0, 1'b0, 1'b0};
    localparam out_word_t SAME_DATE_WORD  = '{STATUS_OK, '0, 1'b0, 1'b1};
    localparam out_word_t NEXT_DAY_WORD   = '{STATUS_OK, 20'sd1, 1'b1, 1'b0};
    localparam out_word_t PREV_DAY_WORD   = '{STATUS_OK, -20'sd1, 1'b0, 1'b0};

    typedef struct {
        in_word_t  w;
        bit        typed;
        out_word_t want;
    } plan_row_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_word;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_word;

    out_word_t   pending_results[$];
    plan_row_t   date_plan[$];
    int unsigned errors = 0;

    // Idle pattern state, one set per side
    int unsigned tx_left = 0;
    bit          tx_busy = 1'b0;
    int unsigned rx_left = 0;
    bit          rx_busy = 1'b0;

    date_day_difference dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Run limit, far above the slowest legal run
    initial begin
        #5000000;
        $display("Test completed with failures");
        $finish;
    end

    // ---------------- calendar predictor ----------------

    function automatic bit leap_year(int unsigned y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    // m must be 1..12
    function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
        int unsigned len;
        case (m)
            2:             len = leap_year(y) ? 29 : 28;
            4, 6, 9, 11:   len = 30;
            default:       len = 31;
        endcase
        return len;
    endfunction

    function automatic bit date_valid(int unsigned d, int unsigned m, int unsigned y);
        if (m < 1 || m > 12) return 1'b0;
        if (y < 1583 || y > 2399) return 1'b0;
        return d >= 1 && d <= days_in_month(m, y);
    endfunction

    // Days since a fixed epoch for a valid date
    function automatic int unsigned serial_day(int unsigned d, int unsigned m,
                                               int unsigned y);
        int unsigned p;
        int unsigned n;
        int unsigned k;
        p = y - 1;
        n = 365 * p + p / 4 - p / 100 + p / 400;
        for (k = 1; k < m; k++) n += days_in_month(k, y);
        return n + d;
    endfunction

    function automatic out_word_t predict_difference(in_word_t w);
        out_word_t   r;
        int          n1;
        int          n2;
        int          diff;
        int unsigned d1;
        int unsigned m1;
        int unsigned y1;
        int unsigned d2;
        int unsigned m2;
        int unsigned y2;
        r  = '0;
        d1 = 32'(w.first_day);
        m1 = 32'(w.first_month);
        y1 = 32'(w.first_year);
        d2 = 32'(w.second_day);
        m2 = 32'(w.second_month);
        y2 = 32'(w.second_year);
        if (!date_valid(d1, m1, y1)) begin
            r.status = STATUS_FIRST_BAD;
        end else if (!date_valid(d2, m2, y2)) begin
            r.status = STATUS_SECOND_BAD;
        end else begin
            n1 = serial_day(d1, m1, y1);
            n2 = serial_day(d2, m2, y2);
            diff = n2 - n1;
            r.status         = STATUS_OK;
            r.day_difference = diff[DNUM_W-1:0];
            r.first_earlier  = n1 < n2;
            r.same_date      = n1 == n2;
        end
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic in_word_t mk_word(int unsigned d1, int unsigned m1, int unsigned y1,
                                         int unsigned d2, int unsigned m2, int unsigned y2);
        in_word_t w;
        w.first_day    = d1[DAY_W-1:0];
        w.first_month  = m1[MONTH_W-1:0];
        w.first_year   = y1[YEAR_W-1:0];
        w.second_day   = d2[DAY_W-1:0];
        w.second_month = m2[MONTH_W-1:0];
        w.second_year  = y2[YEAR_W-1:0];
        return w;
    endfunction

    function automatic void add_row(in_word_t w, bit typed, out_word_t want);
        plan_row_t row;
        row.w     = w;
        row.typed = typed;
        row.want  = want;
        date_plan.push_back(row);
    endfunction

    // Gap before the next word; draws stretches of idling and of none at random
    function automatic int unsigned draw_gap(inout int unsigned left, inout bit busy);
        if (left == 0) begin
            left = $urandom_range(8, 48);
            busy = $urandom_range(0, 2) != 0;
        end
        left--;
        return busy ? $urandom_range(0, 12) : 0;
    endfunction

    // A valid date, leaning on range ends, century years and month ends
    function automatic void pick_date(output logic [DAY_W-1:0] d,
                                      output logic [MONTH_W-1:0] m,
                                      output logic [YEAR_W-1:0] y);
        int unsigned yr;
        int unsigned mo;
        int unsigned len;
        case ($urandom_range(0, 9))
            0:       yr = 1583;
            1:       yr = 2399;
            2:       yr = 1600 + 100 * $urandom_range(0, 7);
            default: yr = $urandom_range(1583, 2399);
        endcase
        mo = $urandom_range(1, 12);
        len = days_in_month(mo, yr);
        case ($urandom_range(0, 5))
            0:       d = 5'd1;
            1:       d = len[DAY_W-1:0];
            default: d = DAY_W'($urandom_range(1, len));
        endcase
        m = mo[MONTH_W-1:0];
        y = yr[YEAR_W-1:0];
    endfunction

    function automatic in_word_t random_word();
        in_word_t    w;
        int unsigned kind;
        int unsigned len;
        logic [DAY_W-1:0]   bd;
        logic [MONTH_W-1:0] bm;
        logic [YEAR_W-1:0]  by;
        bit          on_second;
        kind = $urandom_range(0, 19);
        pick_date(w.first_day, w.first_month, w.first_year);
        pick_date(w.second_day, w.second_month, w.second_year);
        if (kind < 2) begin
            // identical dates
            w.second_day   = w.first_day;
            w.second_month = w.first_month;
            w.second_year  = w.first_year;
        end else if (kind < 4) begin
            // dates in the same year
            w.second_year = w.first_year;
        end else if (kind < 7) begin
            // one field outside the valid set
            on_second = 1'($urandom_range(0, 1));
            bd = on_second ? w.second_day : w.first_day;
            bm = on_second ? w.second_month : w.first_month;
            by = on_second ? w.second_year : w.first_year;
            len = days_in_month(32'(bm), 32'(by));
            case ($urandom_range(0, 5))
                0: bd = '0;
                1: bd = (len < 31) ? DAY_W'($urandom_range(len + 1, 31)) : 5'd0;
                2: bm = '0;
                3: bm = MONTH_W'($urandom_range(13, 15));
                4: by = YEAR_W'($urandom_range(0, 1582));
                default: by = YEAR_W'($urandom_range(2400, 4095));
            endcase
            if (on_second) begin
                w.second_day = bd; w.second_month = bm; w.second_year = by;
            end else begin
                w.first_day = bd; w.first_month = bm; w.first_year = by;
            end
        end else if (kind < 10) begin
            // raw noise over every bit
            w = mk_word($urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 4095),
                        $urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 4095));
        end
        return w;
    endfunction

    // Offer one word and hold it until taken
    task automatic send_word(input in_word_t w, input out_word_t want);
        int unsigned gap;
        gap = draw_gap(tx_left, tx_busy);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= w;
        do @(posedge aclk); while (s_ready !== 1'b1);
        pending_results.push_back(want);
    endtask

    // ---------------- main sequence ----------------

    initial begin
        in_word_t w;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_word  <= '0;

        // Directed table
        add_row(mk_word(1, 1, 1583, 31, 12, 2399), 1'b0, '0);
        add_row(mk_word(31, 12, 2399, 1, 1, 1583), 1'b0, '0);
        add_row(mk_word(1, 1, 1583, 1, 1, 1583), 1'b1, SAME_DATE_WORD);
        add_row(mk_word(31, 12, 2399, 31, 12, 2399), 1'b1, SAME_DATE_WORD);
        add_row(mk_word(28, 2, 2000, 29, 2, 2000), 1'b1, NEXT_DAY_WORD);
        add_row(mk_word(29, 2, 2000, 28, 2, 2000), 1'b1, PREV_DAY_WORD);
        add_row(mk_word(29, 2, 1600, 1, 3, 1600), 1'b1, NEXT_DAY_WORD);
        add_row(mk_word(31, 12, 1999, 1, 1, 2000), 1'b1, NEXT_DAY_WORD);
        add_row(mk_word(1, 3, 2399, 28, 2, 2399), 1'b1, PREV_DAY_WORD);
        add_row(mk_word(15, 6, 1700, 15, 6, 2300), 1'b0, '0);
        // Feb 29 in a century year that is not leap
        add_row(mk_word(29, 2, 1900, 1, 1, 2000), 1'b1, FIRST_BAD_WORD);
        add_row(mk_word(29, 2, 2004, 29, 2, 2100), 1'b1, SECOND_BAD_WORD);
        // Month out of range
        add_row(mk_word(10, 0, 2000, 10, 1, 2000), 1'b1, FIRST_BAD_WORD);
        add_row(mk_word(10, 13, 2000, 10, 1, 2000), 1'b1, FIRST_BAD_WORD);
        add_row(mk_word(10, 5, 2000, 10, 15, 2000), 1'b1, SECOND_BAD_WORD);
        // Day zero and day past month end
        add_row(mk_word(0, 7, 1800, 1, 7, 1800), 1'b1, FIRST_BAD_WORD);
        add_row(mk_word(1, 7, 1800, 0, 7, 1800), 1'b1, SECOND_BAD_WORD);
        add_row(mk_word(31, 4, 2020, 1, 5, 2020), 1'b1, FIRST_BAD_WORD);
        // Years just outside the range
        add_row(mk_word(31, 12, 1582, 1, 1, 1583), 1'b1, FIRST_BAD_WORD);
        add_row(mk_word(31, 12, 2399, 1, 1, 2400), 1'b1, SECOND_BAD_WORD);
        // Both invalid reports the first; a valid first with a bad second reports the second
        add_row(mk_word(0, 0, 0, 0, 0, 0), 1'b1, FIRST_BAD_WORD);
        add_row(mk_word(31, 15, 4095, 31, 15, 4095), 1'b1, FIRST_BAD_WORD);
        add_row(mk_word(1, 1, 2000, 31, 15, 4095), 1'b1, SECOND_BAD_WORD);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (date_plan[i]) begin
            send_word(date_plan[i].w,
                      date_plan[i].typed ? date_plan[i].want : predict_difference(date_plan[i].w));
        end

        repeat (NUM_RANDOM) begin
            w = random_word();
            send_word(w, predict_difference(w));
        end
        s_valid <= 1'b0;

        // Drain, then watch for stray words
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Result side back-pressure
    initial begin
        int unsigned gap;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            gap = draw_gap(rx_left, rx_busy);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
        end
    end

    // Compare each taken result word with the oldest expectation
    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result word with none expected: expected none, actual %p",
                         $time, m_word);
            end else begin
                want = pending_results.pop_front();
                if (m_word.status !== want.status) begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_word.status);
                end
                if (m_word.day_difference !== want.day_difference) begin
                    errors++;
                    $display("%0t: day_difference expected %0d actual %0d",
                             $time, want.day_difference, m_word.day_difference);
                end
                if (m_word.first_earlier !== want.first_earlier) begin
                    errors++;
                    $display("%0t: first_earlier expected %0b actual %0b",
                             $time, want.first_earlier, m_word.first_earlier);
                end
                if (m_word.same_date !== want.same_date) begin
                    errors++;
                    $display("%0t: same_date expected %0b actual %0b",
                             $time, want.same_date, m_word.same_date);
                end
            end
        end
    end

endmodule
